// File: sv/sog_pkg.sv
// shared constants and types for the square occupancy grid
package sog_pkg;

    // fixed field widths
    localparam int SIDE_W = 6;
    localparam int POS_W  = 6;
    localparam int CMP_W  = 7;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 5;
    localparam int KIND_W = 2;

    // board limits
    localparam int MAX_SIDE_DEF = 32;
    localparam logic [SIDE_W-1:0] BOARD_RESET = 6'd32;
    localparam logic [SIDE_W-1:0] MIN_SIDE    = 6'd2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PLACE = 2'd2;

    // running status gathered by the scan head, both without and with the placement
    typedef struct packed {
        logic             conflict;
        logic [CNT_W-1:0] count;
        logic             comp_n;
        logic             found_n;
        logic [POS_W-1:0] frow_n;
        logic [POS_W-1:0] fcol_n;
        logic             comp_p;
        logic             found_p;
        logic [POS_W-1:0] frow_p;
        logic [POS_W-1:0] fcol_p;
    } t_scan_res;

endpackage

// File: sv/sog_cell.sv
// one ring cell holding a single row occupancy word
module sog_cell #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_clear,
    input  logic         i_shift,
    input  logic [W-1:0] i_word,
    input  logic         i_or_en,
    input  logic [W-1:0] i_or_mask,
    output logic [W-1:0] o_word
);

    logic [W-1:0] r_word;

    // clear, rotate to neighbor, or merge a placed square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else if (i_clear) begin
            r_word <= '0;
        end else if (i_shift) begin
            r_word <= i_word;
        end else if (i_or_en) begin
            r_word <= r_word | i_or_mask;
        end
    end

    assign o_word = r_word;

endmodule

// File: sv/sog_scan.sv
// scan head: fit check and board status over one row word per cycle while i_step is high
module sog_scan #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_start,
    input  logic                  i_step,
    input  logic [W-1:0]          i_word,
    input  logic [sog_pkg::POS_W-1:0] i_row_idx,
    input  logic                  i_in_board,
    input  logic                  i_in_sq,
    input  logic [W-1:0]          i_mask,
    input  logic [W-1:0]          i_full,
    output sog_pkg::t_scan_res    o_res
);
    import sog_pkg::*;

    t_scan_res        r_res;
    logic [W-1:0]     w_or;
    logic [W-1:0]     w_occ_n;
    logic [W-1:0]     w_occ_p;
    logic [W-1:0]     w_fr_n;
    logic [W-1:0]     w_fr_p;
    logic [CMP_W-1:0] w_pop;
    logic [POS_W-1:0] w_top_n;
    logic [POS_W-1:0] w_top_p;

    // occupancy of this row without and with the square merged
    always_comb begin
        w_or    = i_in_sq ? i_mask : '0;
        w_occ_n = i_word & i_full;
        w_occ_p = (i_word | w_or) & i_full;
        w_fr_n  = ~i_word & i_full;
        w_fr_p  = ~(i_word | w_or) & i_full;
    end

    // cell count of the row
    always_comb begin
        w_pop = '0;
        for (int b = 0; b < W; b++) begin
            w_pop = w_pop + CMP_W'(w_occ_n[b]);
        end
    end

    // highest free column, both variants
    always_comb begin
        w_top_n = '0;
        w_top_p = '0;
        for (int b = 0; b < W; b++) begin
            if (w_fr_n[b]) begin
                w_top_n = POS_W'(b);
            end
            if (w_fr_p[b]) begin
                w_top_p = POS_W'(b);
            end
        end
    end

    // accumulate; later rows override the free position
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_res.conflict <= 1'b0;
            r_res.count    <= '0;
            r_res.comp_n   <= 1'b1;
            r_res.found_n  <= 1'b0;
            r_res.frow_n   <= '0;
            r_res.fcol_n   <= '0;
            r_res.comp_p   <= 1'b1;
            r_res.found_p  <= 1'b0;
            r_res.frow_p   <= '0;
            r_res.fcol_p   <= '0;
        end else if (i_step) begin
            if (i_in_sq && (|(i_word & i_mask))) begin
                r_res.conflict <= 1'b1;
            end
            if (i_in_board) begin
                r_res.count <= r_res.count + CNT_W'(w_pop);
                if (w_occ_n != i_full) begin
                    r_res.comp_n <= 1'b0;
                end
                if (w_occ_p != i_full) begin
                    r_res.comp_p <= 1'b0;
                end
                if (|w_fr_n) begin
                    r_res.found_n <= 1'b1;
                    r_res.frow_n  <= i_row_idx;
                    r_res.fcol_n  <= w_top_n;
                end
                if (|w_fr_p) begin
                    r_res.found_p <= 1'b1;
                    r_res.frow_p  <= i_row_idx;
                    r_res.fcol_p  <= w_top_p;
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

// File: sv/square_occupancy_grid.sv
// top level: square occupancy grid with a rotating ring of row cells
// Each item is accepted in the idle state, scanned in the scan state and finished in the done
// state, where its result is registered: the row words sit in a ring of MAX_SIDE cells that
// rotates one row per cycle past a single scan head, which checks the square for overlap and
// gathers the free cell, completeness and filled count for the board both as it is and with
// the square merged; the done state then picks the variant, merges the square into the rows
// it covers and loads the result register once the output is free. A clear empties every
// cell in the accept cycle and the scan then reports the empty board. A finished result
// waiting on i_stall does not keep the next item out, but that item holds after its scan
// until the waiting result is taken. board_side may only be written while no item is in
// progress.
module square_occupancy_grid #(
    parameter int MAX_SIDE = sog_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sog_pkg::SIDE_W-1:0]  i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [sog_pkg::KIND_W-1:0]  i_kind,
    input  logic [sog_pkg::IDX_W-1:0]   i_row,
    input  logic [sog_pkg::IDX_W-1:0]   i_col,
    input  logic [sog_pkg::SIDE_W-1:0]  i_side,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_fits,
    output logic                        o_free_found,
    output logic [sog_pkg::IDX_W-1:0]   o_free_row,
    output logic [sog_pkg::IDX_W-1:0]   o_free_col,
    output logic                        o_complete,
    output logic [sog_pkg::CNT_W-1:0]   o_filled_cells
);
    import sog_pkg::*;

    localparam int RW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam logic [RW-1:0] LAST_ROW = RW'(MAX_SIDE - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state               r_state;
    logic [SIDE_W-1:0]    r_board_side;
    logic [RW-1:0]        r_idx;
    logic [KIND_W-1:0]    r_kind;
    logic [IDX_W-1:0]     r_row;
    logic [IDX_W-1:0]     r_col;
    logic [SIDE_W-1:0]    r_side;
    logic [CNT_W-1:0]     r_area;
    logic                 r_o_valid;
    logic                 r_fits;
    logic                 r_free_found;
    logic [IDX_W-1:0]     r_free_row;
    logic [IDX_W-1:0]     r_free_col;
    logic                 r_complete;
    logic [CNT_W-1:0]     r_filled;

    logic [SIDE_W-1:0]    w_n;
    logic [MAX_SIDE-1:0]  w_mask;
    logic [MAX_SIDE-1:0]  w_full;
    logic [MAX_SIDE-1:0]  w_word [MAX_SIDE];
    logic                 w_accept;
    logic                 w_clear;
    logic                 w_geom_ok;
    logic                 w_fit;
    logic                 w_apply;
    logic                 w_out_free;
    logic                 w_in_board;
    logic                 w_in_sq;
    logic [CMP_W-1:0]     w_idx;
    logic [CMP_W-1:0]     w_r_end;
    logic [CMP_W-1:0]     w_c_end;
    t_scan_res            w_res;

    // handshake
    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_clear    = w_accept && (i_kind == KIND_CLEAR);
    assign w_out_free = !r_o_valid || !i_stall;

    // board size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_side <= BOARD_RESET;
        end else if (i_cfg_we) begin
            r_board_side <= i_cfg_wdata;
        end
    end

    // effective board side, clamped to the supported range
    always_comb begin
        if (r_board_side < MIN_SIDE) begin
            w_n = MIN_SIDE;
        end else if (r_board_side > SIDE_W'(MAX_SIDE)) begin
            w_n = SIDE_W'(MAX_SIDE);
        end else begin
            w_n = r_board_side;
        end
    end

    // square geometry
    assign w_r_end = CMP_W'(r_row) + CMP_W'(r_side);
    assign w_c_end = CMP_W'(r_col) + CMP_W'(r_side);
    assign w_geom_ok = (r_side != '0) && (r_side < w_n) &&
                       (w_r_end <= CMP_W'(w_n)) && (w_c_end <= CMP_W'(w_n));

    // column masks for the square and the board
    always_comb begin
        for (int b = 0; b < MAX_SIDE; b++) begin
            w_mask[b] = (CMP_W'(b) >= CMP_W'(r_col)) && (CMP_W'(b) < w_c_end);
            w_full[b] = (CMP_W'(b) < CMP_W'(w_n));
        end
    end

    // row flags for the word now at the scan head
    assign w_idx      = CMP_W'(r_idx);
    assign w_in_board = (w_idx < CMP_W'(w_n));
    assign w_in_sq    = (w_idx >= CMP_W'(r_row)) && (w_idx < w_r_end);

    // final decision
    assign w_fit   = w_geom_ok && !w_res.conflict &&
                     ((r_kind == KIND_TEST) || (r_kind == KIND_PLACE));
    assign w_apply = (r_state == S_DONE) && w_out_free && w_fit && (r_kind == KIND_PLACE);

    // ring of row cells, rotating toward cell zero
    for (genvar g = 0; g < MAX_SIDE; g++) begin : g_cell
        logic w_or_en;
        assign w_or_en = w_apply && (CMP_W'(g) >= CMP_W'(r_row)) && (CMP_W'(g) < w_r_end);
        sog_cell #(
            .W (MAX_SIDE)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (w_clear),
            .i_shift   (r_state == S_SCAN),
            .i_word    (w_word[(g + 1) % MAX_SIDE]),
            .i_or_en   (w_or_en),
            .i_or_mask (w_mask),
            .o_word    (w_word[g])
        );
    end

    // scan head on cell zero
    sog_scan #(
        .W (MAX_SIDE)
    ) u_scan (
        .i_clk      (i_clk),
        .i_start    (w_accept),
        .i_step     (r_state == S_SCAN),
        .i_word     (w_word[0]),
        .i_row_idx  (POS_W'(r_idx)),
        .i_in_board (w_in_board),
        .i_in_sq    (w_in_sq),
        .i_mask     (w_mask),
        .i_full     (w_full),
        .o_res      (w_res)
    );

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_row  <= i_row;
            r_col  <= i_col;
            r_side <= i_side;
            r_area <= CNT_W'(i_side) * CNT_W'(i_side);
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == LAST_ROW) begin
                        r_idx   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_fits    <= w_fit;
                        if (w_apply) begin
                            r_free_found <= w_res.found_p;
                            r_free_row   <= w_res.frow_p[IDX_W-1:0];
                            r_free_col   <= w_res.fcol_p[IDX_W-1:0];
                            r_complete   <= w_res.comp_p;
                            r_filled     <= w_res.count + r_area;
                        end else begin
                            r_free_found <= w_res.found_n;
                            r_free_row   <= w_res.frow_n[IDX_W-1:0];
                            r_free_col   <= w_res.fcol_n[IDX_W-1:0];
                            r_complete   <= w_res.comp_n;
                            r_filled     <= w_res.count;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_fits         = r_fits;
    assign o_free_found   = r_free_found;
    assign o_free_row     = r_free_row;
    assign o_free_col     = r_free_col;
    assign o_complete     = r_complete;
    assign o_filled_cells = r_filled;

endmodule
